// ===== hw/rtl/array_list_insert_delete_locate_assert.svh =====
// Assertion macros shared by the list checker
`ifndef ARRAY_LIST_INSERT_DELETE_LOCATE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_LOCATE_ASSERT_SVH

// a holds, so b holds in the same cycle
`define ALIDL_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("list checker: implication failed");

// a holds, so b holds in the next cycle
`define ALIDL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("list checker: next-cycle implication failed");

`endif

// ===== hw/rtl/alidl_pkg.sv =====
// Shared widths and operation codes of the array list
package alidl_pkg;

    localparam int OP_W    = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int FOUND_W = 8;
    localparam int LEN_W   = 8;

    localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_GET    = OP_W'(1);
    localparam logic [OP_W-1:0] OP_LOCATE = OP_W'(2);
    localparam logic [OP_W-1:0] OP_INSERT = OP_W'(3);
    localparam logic [OP_W-1:0] OP_DELETE = OP_W'(4);

endpackage

// ===== hw/rtl/alidl_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module alidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/array_list_insert_delete_locate.sv =====
// Bounded ordered list in one RAM: clear, get, locate, insert, delete
// Clear and rejected words use no RAM; get reads one entry; locate scans to a match or the end;
// insert shifts entries from the end down to the position, then writes the value; delete
// shifts later entries back. One word at a time: a new word is taken in the o_done cycle.
// Result appears for one cycle with o_done; the receiver cannot stall.
// Reset (synchronous, active low) clears the length and control; the RAM is not cleared.
module array_list_insert_delete_locate #(
    parameter int CAPACITY = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [alidl_pkg::OP_W-1:0]          i_operation,
    input  logic [alidl_pkg::POS_W-1:0]         i_position,
    input  logic signed [alidl_pkg::VAL_W-1:0]  i_value,
    output logic                                o_done,
    output logic                                o_status,
    output logic signed [alidl_pkg::VAL_W-1:0]  o_read_value,
    output logic [alidl_pkg::FOUND_W-1:0]       o_found_position,
    output logic [alidl_pkg::LEN_W-1:0]         o_list_length
);

    import alidl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_LOC,
        S_INS,
        S_DEL
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_pidx, n_pidx;
    logic                r_pend, n_pend;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [VAL_W-1:0]    r_value, n_value;
    logic                r_done, n_done;
    logic                r_status, n_status;
    logic [VAL_W-1:0]    r_rdval, n_rdval;
    logic [FOUND_W-1:0]  r_found, n_found;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_wa, ram_ra;
    logic [VAL_W-1:0]    ram_wd, ram_rd;

    logic [PW-1:0]       pos_x, rpos_x, cnt_x, cap_x;
    logic [CW-1:0]       idx_dec, pidx_dec;
    logic                hit;

    alidl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    assign pos_x    = PW'(i_position);
    assign rpos_x   = PW'(r_pos);
    assign cnt_x    = PW'(r_count);
    assign cap_x    = PW'(CAPACITY);
    assign idx_dec  = r_idx - CW'(1);
    assign pidx_dec = r_pidx - CW'(1);
    assign hit      = r_pend && (ram_rd == r_value);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = r_pend;
        n_pos    = r_pos;
        n_value  = r_value;
        n_done   = 1'b0;
        n_status = 1'b0;
        n_rdval  = '0;
        n_found  = '0;
        ram_we   = 1'b0;
        ram_wa   = '0;
        ram_wd   = '0;
        ram_re   = 1'b0;
        ram_ra   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pend  = 1'b0;
                    n_pos   = i_position;
                    n_value = i_value;
                    unique case (i_operation)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        OP_GET: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_done   = 1'b1;
                                n_status = 1'b1;
                            end else begin
                                ram_re  = 1'b1;
                                ram_ra  = AW'(pos_x - PW'(1));
                                n_state = S_GET;
                            end
                        end
                        OP_LOCATE: begin
                            n_idx   = '0;
                            n_state = S_LOC;
                        end
                        OP_INSERT: begin
                            if (pos_x == '0 || pos_x > cnt_x + PW'(1) || cnt_x >= cap_x) begin
                                n_done   = 1'b1;
                                n_status = 1'b1;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_done   = 1'b1;
                                n_status = 1'b1;
                            end else begin
                                n_idx   = CW'(pos_x);
                                n_state = S_DEL;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = 1'b1;
                        end
                    endcase
                end
            end
            S_GET: begin
                n_done  = 1'b1;
                n_rdval = ram_rd;
                n_state = S_IDLE;
            end
            S_LOC: begin
                priority if (hit) begin
                    n_done  = 1'b1;
                    n_found = FOUND_W'(PW'(r_pidx) + PW'(1));
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end else if (r_idx >= r_count) begin
                    n_done  = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    ram_re = 1'b1;
                    ram_ra = r_idx[AW-1:0];
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end
            end
            S_INS: begin
                if (r_pend) begin
                    ram_we = 1'b1;
                    ram_wa = r_pidx[AW-1:0];
                    ram_wd = ram_rd;
                    n_pend = 1'b0;
                end
                priority if (PW'(r_idx) >= rpos_x) begin
                    ram_re = 1'b1;
                    ram_ra = idx_dec[AW-1:0];
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = idx_dec;
                end else if (!r_pend) begin
                    ram_we  = 1'b1;
                    ram_wa  = AW'(rpos_x - PW'(1));
                    ram_wd  = r_value;
                    n_count = r_count + CW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                if (r_pend) begin
                    ram_we = 1'b1;
                    ram_wa = pidx_dec[AW-1:0];
                    ram_wd = ram_rd;
                    n_pend = 1'b0;
                end
                priority if (r_idx < r_count) begin
                    ram_re = 1'b1;
                    ram_ra = r_idx[AW-1:0];
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_status <= n_status;
        r_rdval  <= n_rdval;
        r_found  <= n_found;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_read_value     = $signed(r_rdval);
    assign o_found_position = r_found;
    assign o_list_length    = LEN_W'(r_count);

endmodule

// ===== hw/rtl/alidl_checker.sv =====
// Port-level checker for the array list, bound to the top level
`include "array_list_insert_delete_locate_assert.svh"

module alidl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [alidl_pkg::OP_W-1:0]          i_operation,
    input logic                                o_done,
    input logic                                o_status,
    input logic signed [alidl_pkg::VAL_W-1:0]  o_read_value,
    input logic [alidl_pkg::FOUND_W-1:0]       o_found_position,
    input logic [alidl_pkg::LEN_W-1:0]         o_list_length
);

    import alidl_pkg::*;

    logic word_taken;
    logic clear_taken;
    logic cleared;
    logic error_quiet;

    assign word_taken  = start && !busy;
    assign clear_taken = word_taken && (i_operation == OP_CLEAR);
    assign cleared     = o_done && !o_status && (o_list_length == '0);
    assign error_quiet = (o_read_value == '0) && (o_found_position == '0);

    `ALIDL_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, clear_taken, cleared)
    `ALIDL_ASSERT_NEXT(a_word_taken, i_clk, i_rst_n, word_taken, o_done || busy)
    `ALIDL_ASSERT_IMPLY(a_error_zeroes, i_clk, i_rst_n, o_done && o_status, error_quiet)
    `ALIDL_ASSERT_IMPLY(a_length_at_done, i_clk, i_rst_n, !$stable(o_list_length), o_done)

endmodule

bind array_list_insert_delete_locate alidl_checker u_alidl_checker (.*);

// ===== tb/tb_array_list_insert_delete_locate.sv =====
// Testbench for the array list: directed and random words checked against a list predictor
`timescale 1ns / 100ps

module tb_array_list_insert_delete_locate;
    import alidl_pkg::*;

    localparam int  CAPACITY    = 128;
    localparam int  RAND_WORDS  = 925;
    localparam int  PHASE_WORDS = 185;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = CAPACITY + 20;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

    typedef struct {
        logic                    status;
        logic signed [VAL_W-1:0] read_value;
        logic [FOUND_W-1:0]      found_position;
        logic [LEN_W-1:0]        list_length;
    } list_result_t;

    class list_scoreboard;
        logic [VAL_W-1:0] store [CAPACITY];
        int               count;
        int               errors;
        list_result_t     pending [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] val);
            list_result_t r;
            int           p;
            int           k;
            p = pos;
            r.status         = 1'b0;
            r.read_value     = '0;
            r.found_position = '0;
            case (op)
                OP_CLEAR: begin
                    count = 0;
                end
                OP_GET: begin
                    if (p < 1 || p > count) begin
                        r.status = 1'b1;
                    end else begin
                        r.read_value = store[p-1];
                    end
                end
                OP_LOCATE: begin
                    for (k = 0; k < count && r.found_position == 0; k++) begin
                        if (store[k] == val) begin
                            r.found_position = FOUND_W'(k + 1);
                        end
                    end
                end
                OP_INSERT: begin
                    if (p < 1 || p > count + 1 || count >= CAPACITY) begin
                        r.status = 1'b1;
                    end else begin
                        for (k = count; k >= p; k--) begin
                            store[k] = store[k-1];
                        end
                        store[p-1] = val;
                        count++;
                    end
                end
                OP_DELETE: begin
                    if (p < 1 || p > count) begin
                        r.status = 1'b1;
                    end else begin
                        for (k = p; k < count; k++) begin
                            store[k-1] = store[k];
                        end
                        count--;
                    end
                end
                default: begin
                    r.status = 1'b1;
                end
            endcase
            r.list_length = LEN_W'(count);
            pending.push_back(r);
        endfunction

        function void check_result(logic st, logic signed [VAL_W-1:0] rd,
                                   logic [FOUND_W-1:0] fp, logic [LEN_W-1:0] len);
            list_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result: status %0b read %0d found %0d length %0d",
                         $time, st, rd, fp, len);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t: status mismatch: expected %0b actual %0b",
                         $time, e.status, st);
                errors++;
            end
            if (rd !== e.read_value) begin
                $display("%0t: read_value mismatch: expected %0d actual %0d",
                         $time, e.read_value, rd);
                errors++;
            end
            if (fp !== e.found_position) begin
                $display("%0t: found_position mismatch: expected %0d actual %0d",
                         $time, e.found_position, fp);
                errors++;
            end
            if (len !== e.list_length) begin
                $display("%0t: list_length mismatch: expected %0d actual %0d",
                         $time, e.list_length, len);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         i_operation;
    logic [POS_W-1:0]        i_position;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_done;
    logic                    o_status;
    logic signed [VAL_W-1:0] o_read_value;
    logic [FOUND_W-1:0]      o_found_position;
    logic [LEN_W-1:0]        o_list_length;

    list_scoreboard sb;
    int             cycles;
    int             calm_words;

    array_list_insert_delete_locate #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_found_position(o_found_position),
        .o_list_length   (o_list_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_done) begin
            sb.check_result(o_status, o_read_value, o_found_position, o_list_length);
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_words > 0) begin
            calm_words--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) begin
            calm_words = $urandom_range(20, 60);
        end
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW: begin
                if (r < 80) return OP_INSERT;
                if (r < 85) return OP_DELETE;
                if (r < 91) return OP_GET;
                if (r < 97) return OP_LOCATE;
            end
            PH_SHRINK: begin
                if (r < 75) return OP_DELETE;
                if (r < 82) return OP_INSERT;
                if (r < 90) return OP_GET;
                if (r < 97) return OP_LOCATE;
            end
            default: begin
                if (r < 30) return OP_INSERT;
                if (r < 55) return OP_DELETE;
                if (r < 75) return OP_GET;
                if (r < 93) return OP_LOCATE;
                if (r < 96) return OP_CLEAR;
            end
        endcase
        return OP_W'(OP_DELETE + $urandom_range(1, 3));
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(logic [OP_W-1:0] op);
        int top;
        int r;
        top = (op == OP_INSERT) ? sb.count + 1 : sb.count;
        r = $urandom_range(0, 99);
        if (r < 80 && top >= 1) return POS_W'($urandom_range(1, top));
        if (r < 90) return ($urandom_range(0, 1) == 0) ? POS_W'(0) : POS_W'(top + 1);
        return POS_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && sb.count > 0) return sb.store[$urandom_range(0, sb.count - 1)];
        if (r < 70) return VAL_W'($signed($urandom_range(0, 7)) - 3);
        return $urandom;
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [VAL_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        do @(posedge i_clk); while (busy);
        sb.note_word(op, pos, val);
        @(negedge i_clk);
    endtask

    initial begin
        logic [OP_W-1:0] op;
        phase_t          ph;
        sb          = new();
        cycles      = 0;
        calm_words  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = OP_CLEAR;
        i_position  = '0;
        i_value     = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(OP_GET,    8'd1,   32'd0);
        send_word(OP_DELETE, 8'd1,   32'd0);
        send_word(OP_LOCATE, 8'd0,   32'd0);
        send_word(OP_INSERT, 8'd0,   32'd5);
        send_word(OP_INSERT, 8'd2,   32'd5);
        send_word(OP_INSERT, 8'd1,   32'h7FFF_FFFF);
        send_word(OP_INSERT, 8'd1,   32'h8000_0000);
        send_word(OP_INSERT, 8'd3,   32'hFFFF_FFFF);
        send_word(OP_INSERT, 8'd2,   32'h7FFF_FFFF);
        send_word(OP_LOCATE, 8'd0,   32'h7FFF_FFFF);
        send_word(OP_LOCATE, 8'd255, 32'h8000_0000);
        send_word(OP_LOCATE, 8'd0,   32'd12345);
        send_word(OP_GET,    8'd0,   32'd0);
        send_word(OP_GET,    8'd4,   32'd0);
        send_word(OP_GET,    8'd5,   32'd0);
        send_word(OP_GET,    8'd255, 32'd0);
        send_word(OP_INSERT, 8'd255, 32'd9);
        send_word(OP_DELETE, 8'd5,   32'd0);
        send_word(OP_DELETE, 8'd4,   32'd0);
        send_word(OP_DELETE, 8'd1,   32'd0);
        send_word(OP_DELETE, 8'd0,   32'd0);
        send_word(OP_W'(OP_DELETE + 1), 8'd255, 32'hFFFF_FFFF);
        send_word(OP_W'(OP_DELETE + 2), 8'd1,   32'h8000_0000);
        send_word(OP_W'(OP_DELETE + 3), 8'd0,   32'h7FFF_FFFF);
        send_word(OP_CLEAR,  8'd255, 32'hFFFF_FFFF);

        for (int i = 0; i < RAND_WORDS; i++) begin
            case ((i / PHASE_WORDS) % 5)
                0, 3:    ph = PH_GROW;
                1:       ph = PH_SHRINK;
                default: ph = PH_MIXED;
            endcase
            op = pick_op(ph);
            send_word(op, pick_pos(op), pick_value());
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/alidl_pkg.sv
hw/rtl/alidl_ram.sv
hw/rtl/array_list_insert_delete_locate.sv
hw/rtl/alidl_checker.sv
tb/tb_array_list_insert_delete_locate.sv
